// ===== hdl/lsps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsps_pkg;

  // Sensor array and field widths
  localparam int unsigned SensorCount = 8;
  localparam int unsigned ErrW        = 4;
  localparam int unsigned DiffW       = 5;
  localparam int unsigned GainW       = 16;
  localparam int unsigned IntegW      = 32;
  localparam int unsigned DriveW      = 31;
  localparam int unsigned CfgIdxW     = 2;

  // Product and sum widths
  localparam int unsigned PropW  = GainW + ErrW;
  localparam int unsigned IntPW  = GainW + IntegW;
  localparam int unsigned DerivW = GainW + DiffW;
  localparam int unsigned SumW   = IntPW + 2;

  typedef logic signed [ErrW-1:0]   err_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [GainW-1:0]  gain_t;
  typedef logic signed [IntegW-1:0] integ_t;
  typedef logic [DriveW-1:0]        drive_t;

  // Sensor weights, sensor 0 first
  localparam logic signed [ErrW-1:0] SensorWeight [SensorCount] =
    '{-4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd0, 4'sd1, 4'sd2, 4'sd3};

  // Special sample patterns
  localparam logic [SensorCount-1:0] NodeAligned = 8'h99;
  localparam logic [SensorCount-1:0] NodeRight   = 8'hCC;
  localparam logic [SensorCount-1:0] NodeLeft    = 8'h33;
  localparam logic [SensorCount-1:0] Junction120 = 8'h18;
  localparam logic [SensorCount-1:0] CenterMask  = 8'h18;
  localparam logic [SensorCount-1:0] LowerMask   = 8'h0F;
  localparam logic [SensorCount-1:0] UpperMask   = 8'hF0;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegPropGain     = 2'd0,
    RegIntegralGain = 2'd1,
    RegDerivGain    = 2'd2
  } cfg_reg_e;

  // Pattern flags of one sample
  typedef struct packed {
    logic cross_section;
    logic off_line;
    logic node_seen;
    logic junction_120;
    logic turn_90;
    logic false_node;
  } flags_t;

  // Load strobes for the back stages
  typedef struct packed {
    logic load_prod;
    logic load_out;
  } back_ctl_t;

  // Weighted position error of one sample
  function automatic err_t position_error(input logic [SensorCount-1:0] s);
    err_t acc;
    acc = '0;
    for (int i = 0; i < SensorCount; i++) begin
      if (s[i]) begin
        acc = acc + SensorWeight[i];
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/line_sensor_pid_steering.sv =====
// Each item passes through the input, decode/integral, product and result registers.
// Throughput: one item per cycle while out_stall_i is low; each stage moves as soon
// as the stage after it has room.
// Reset: asynchronous, active low; clears the gains, the error integral, the last error
// and all stage valid flags. The configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module line_sensor_pid_steering (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [lsps_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [lsps_pkg::GainW-1:0]         cfg_data_i,
  // input items
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [lsps_pkg::SensorCount-1:0]   sensor_bits_i,
  // result items
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [lsps_pkg::ErrW-1:0]        position_error_o,
  output logic [lsps_pkg::DriveW-1:0]             drive_level_o,
  output logic                                    cross_section_o,
  output logic                                    off_line_o,
  output logic                                    node_seen_o,
  output logic                                    junction_120_o,
  output logic                                    turn_90_o,
  output logic                                    false_node_o
);

  lsps_pkg::gain_t prop_gain_q, integral_gain_q, deriv_gain_q;
  logic            v0_q, v1_q, v2_q, v3_q;
  logic            en0, en1, en2, en3;
  logic [lsps_pkg::SensorCount-1:0] sensor_q;

  lsps_pkg::err_t      s1_err;
  lsps_pkg::integ_t    s1_integ;
  lsps_pkg::diff_t     s1_diff;
  lsps_pkg::flags_t    s1_flags;
  lsps_pkg::back_ctl_t back_ctl;
  lsps_pkg::err_t      out_err;
  lsps_pkg::flags_t    out_flags;

  // Gain registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     <= '0;
      integral_gain_q <= '0;
      deriv_gain_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (lsps_pkg::cfg_reg_e'(cfg_index_i))
        lsps_pkg::RegPropGain:     prop_gain_q     <= cfg_data_i;
        lsps_pkg::RegIntegralGain: integral_gain_q <= cfg_data_i;
        lsps_pkg::RegDerivGain:    deriv_gain_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its item moves on
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign in_stall_o  = !en0;
  assign out_valid_o = v3_q;

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      sensor_q <= sensor_bits_i;
    end
  end

  lsps_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (en1 && v0_q),
    .sensor_i (sensor_q),
    .err_o    (s1_err),
    .integ_o  (s1_integ),
    .diff_o   (s1_diff),
    .flags_o  (s1_flags)
  );

  assign back_ctl.load_prod = en2 && v1_q;
  assign back_ctl.load_out  = en3 && v2_q;

  lsps_back u_back (
    .clk_i           (clk_i),
    .ctl_i           (back_ctl),
    .prop_gain_i     (prop_gain_q),
    .integral_gain_i (integral_gain_q),
    .deriv_gain_i    (deriv_gain_q),
    .err_i           (s1_err),
    .integ_i         (s1_integ),
    .diff_i          (s1_diff),
    .flags_i         (s1_flags),
    .err_o           (out_err),
    .drive_o         (drive_level_o),
    .flags_o         (out_flags)
  );

  assign position_error_o = out_err;
  assign cross_section_o  = out_flags.cross_section;
  assign off_line_o       = out_flags.off_line;
  assign node_seen_o      = out_flags.node_seen;
  assign junction_120_o   = out_flags.junction_120;
  assign turn_90_o        = out_flags.turn_90;
  assign false_node_o     = out_flags.false_node;

endmodule

`default_nettype wire

// ===== hdl/lsps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsps_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                load_i,
  input  wire logic [lsps_pkg::SensorCount-1:0]    sensor_i,
  output lsps_pkg::err_t                           err_o,
  output lsps_pkg::integ_t                         integ_o,
  output lsps_pkg::diff_t                          diff_o,
  output lsps_pkg::flags_t                         flags_o
);

  lsps_pkg::integ_t               integ_q, integ_d;
  lsps_pkg::err_t                 last_err_q;
  lsps_pkg::err_t                 err_d, err_q;
  lsps_pkg::diff_t                diff_d, diff_q;
  lsps_pkg::flags_t               flags_d, flags_q;
  logic signed [lsps_pkg::IntegW:0] integ_sum;

  // Decode the sample and compute the derivative term input
  always_comb begin
    err_d  = lsps_pkg::position_error(sensor_i);
    diff_d = lsps_pkg::DiffW'(err_d) - lsps_pkg::DiffW'(last_err_q);

    flags_d.cross_section = (sensor_i == '0);
    flags_d.off_line      = (sensor_i == '1);
    flags_d.node_seen     = (sensor_i == lsps_pkg::NodeAligned) ||
                            (sensor_i == lsps_pkg::NodeRight) ||
                            (sensor_i == lsps_pkg::NodeLeft);
    flags_d.junction_120  = (sensor_i == lsps_pkg::Junction120);
    flags_d.turn_90       = ((sensor_i & lsps_pkg::LowerMask) == '0) ||
                            ((sensor_i & lsps_pkg::UpperMask) == '0);
    flags_d.false_node    = ((sensor_i & lsps_pkg::CenterMask) == '0);
  end

  // Saturating integral update
  always_comb begin
    integ_sum = (lsps_pkg::IntegW+1)'(integ_q) + (lsps_pkg::IntegW+1)'(err_d);
    if (integ_sum[lsps_pkg::IntegW] != integ_sum[lsps_pkg::IntegW-1]) begin
      integ_d = integ_sum[lsps_pkg::IntegW] ? {1'b1, {(lsps_pkg::IntegW-1){1'b0}}}
                                            : {1'b0, {(lsps_pkg::IntegW-1){1'b1}}};
    end else begin
      integ_d = integ_sum[lsps_pkg::IntegW-1:0];
    end
  end

  // Hold controller state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      last_err_q <= '0;
    end else if (load_i) begin
      integ_q    <= integ_d;
      last_err_q <= err_d;
    end
  end

  // Stage register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_q   <= err_d;
      diff_q  <= diff_d;
      flags_q <= flags_d;
    end
  end

  assign err_o   = err_q;
  assign integ_o = integ_q;
  assign diff_o  = diff_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

// ===== hdl/lsps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsps_back (
  input  wire logic                 clk_i,
  input  wire lsps_pkg::back_ctl_t  ctl_i,
  input  wire lsps_pkg::gain_t      prop_gain_i,
  input  wire lsps_pkg::gain_t      integral_gain_i,
  input  wire lsps_pkg::gain_t      deriv_gain_i,
  input  wire lsps_pkg::err_t       err_i,
  input  wire lsps_pkg::integ_t     integ_i,
  input  wire lsps_pkg::diff_t      diff_i,
  input  wire lsps_pkg::flags_t     flags_i,
  output lsps_pkg::err_t            err_o,
  output lsps_pkg::drive_t          drive_o,
  output lsps_pkg::flags_t          flags_o
);

  logic signed [lsps_pkg::PropW-1:0]  prop_q;
  logic signed [lsps_pkg::IntPW-1:0]  intp_q;
  logic signed [lsps_pkg::DerivW-1:0] deriv_q;
  lsps_pkg::err_t                     err_q, err_out_q;
  lsps_pkg::flags_t                   flags_q, flags_out_q;
  lsps_pkg::drive_t                   drive_d, drive_q;
  logic signed [lsps_pkg::SumW-1:0]   pid_sum;
  logic [lsps_pkg::SumW-1:0]          pid_abs;

  // Product stage: one multiplier per term
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_prod) begin
      prop_q  <= lsps_pkg::PropW'(prop_gain_i) * lsps_pkg::PropW'(err_i);
      intp_q  <= lsps_pkg::IntPW'(integral_gain_i) * lsps_pkg::IntPW'(integ_i);
      deriv_q <= lsps_pkg::DerivW'(deriv_gain_i) * lsps_pkg::DerivW'(diff_i);
      err_q   <= err_i;
      flags_q <= flags_i;
    end
  end

  // Add the terms, take the magnitude and clamp it
  always_comb begin
    pid_sum = lsps_pkg::SumW'(prop_q) + lsps_pkg::SumW'(intp_q)
            + lsps_pkg::SumW'(deriv_q);
    pid_abs = pid_sum[lsps_pkg::SumW-1] ? lsps_pkg::SumW'(-pid_sum)
                                        : lsps_pkg::SumW'(pid_sum);
    if (pid_abs[lsps_pkg::SumW-1:lsps_pkg::DriveW] != '0) begin
      drive_d = '1;
    end else begin
      drive_d = pid_abs[lsps_pkg::DriveW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      drive_q     <= drive_d;
      err_out_q   <= err_q;
      flags_out_q <= flags_q;
    end
  end

  assign err_o   = err_out_q;
  assign drive_o = drive_q;
  assign flags_o = flags_out_q;

endmodule

`default_nettype wire

// ===== tb/line_sensor_pid_checker.sv =====
`timescale 1ns / 1ps

module line_sensor_pid_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [lsps_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [lsps_pkg::GainW-1:0]            cfg_data_i,
  // sensor samples into the block
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic [lsps_pkg::SensorCount-1:0]      sensor_bits_i,
  // steering results out of the block
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [lsps_pkg::ErrW-1:0]      position_error_i,
  input  logic [lsps_pkg::DriveW-1:0]           drive_level_i,
  input  logic                                  cross_section_i,
  input  logic                                  off_line_i,
  input  logic                                  node_seen_i,
  input  logic                                  junction_120_i,
  input  logic                                  turn_90_i,
  input  logic                                  false_node_i,
  // status for the testbench top
  output int unsigned                           mismatch_count_o,
  output int unsigned                           results_pending_o
);

  localparam logic [lsps_pkg::SensorCount-1:0] PatNodeAligned = 8'h99;
  localparam logic [lsps_pkg::SensorCount-1:0] PatNodeRight   = 8'hCC;
  localparam logic [lsps_pkg::SensorCount-1:0] PatNodeLeft    = 8'h33;
  localparam logic [lsps_pkg::SensorCount-1:0] PatJunction    = 8'h18;

  localparam longint SumHi       = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SumLo       = -64'sh0000_0000_8000_0000;
  localparam int unsigned MaxShown = 40;

  typedef struct packed {
    lsps_pkg::err_t   pos_err;
    lsps_pkg::drive_t drive;
    lsps_pkg::flags_t flags;
  } steering_result_t;

  // Own copy of the gains and the PID state
  lsps_pkg::gain_t  kp_gain;
  lsps_pkg::gain_t  ki_gain;
  lsps_pkg::gain_t  kd_gain;
  lsps_pkg::integ_t error_sum;
  int               prev_error;

  steering_result_t expected_steering_q[$];
  int unsigned      result_index;

  // Advance the PID state by one sample and return the result it must give
  function automatic steering_result_t predict_steering(
      input logic [lsps_pkg::SensorCount-1:0] s);
    steering_result_t r;
    int               e;
    longint           acc;
    longint           pid;
    e = 0;
    for (int i = 0; i < lsps_pkg::SensorCount; i++) begin
      if (s[i]) begin
        e += (i < lsps_pkg::SensorCount / 2) ? i - 3 : i - 4;
      end
    end
    // Integral saturates at the 32-bit signed limits
    acc = longint'(error_sum) + longint'(e);
    if (acc > SumHi) acc = SumHi;
    if (acc < SumLo) acc = SumLo;
    error_sum = lsps_pkg::integ_t'(acc);
    pid = longint'(kp_gain) * longint'(e)
        + longint'(ki_gain) * longint'(error_sum)
        + longint'(kd_gain) * (longint'(e) - longint'(prev_error));
    prev_error = e;
    // Drive is the magnitude, clipped to the 31-bit maximum
    if (pid < 0) pid = -pid;
    if (pid > SumHi) pid = SumHi;
    r.pos_err             = lsps_pkg::err_t'(e);
    r.drive               = lsps_pkg::drive_t'(pid);
    r.flags.cross_section = (s == '0);
    r.flags.off_line      = (&s);
    r.flags.node_seen     = (s == PatNodeAligned) || (s == PatNodeRight) ||
                            (s == PatNodeLeft);
    r.flags.junction_120  = (s == PatJunction);
    r.flags.turn_90       = (s[3:0] == '0) || (s[7:4] == '0);
    r.flags.false_node    = (s[4:3] == '0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
    if (mismatch_count_o < MaxShown) begin
      $display("%0t: result %0d %s: got %0d, expected %0d", $time, result_index, what,
               got, want);
    end
    mismatch_count_o++;
  endtask

  task automatic check_field(input string what, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    steering_result_t want;
    if (!rst_ni) begin
      kp_gain      = '0;
      ki_gain      = '0;
      kd_gain      = '0;
      error_sum    = '0;
      prev_error   = 0;
      result_index = 0;
      mismatch_count_o = 0;
      expected_steering_q.delete();
      results_pending_o <= 0;
    end else begin
      // Compare an accepted result against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_steering_q.size() == 0) begin
          report_mismatch("arrived with nothing expected", drive_level_i, 0);
        end else begin
          want = expected_steering_q.pop_front();
          check_field("position_error", position_error_i, want.pos_err);
          check_field("drive_level", drive_level_i, want.drive);
          check_field("cross_section", cross_section_i, want.flags.cross_section);
          check_field("off_line", off_line_i, want.flags.off_line);
          check_field("node_seen", node_seen_i, want.flags.node_seen);
          check_field("junction_120", junction_120_i, want.flags.junction_120);
          check_field("turn_90", turn_90_i, want.flags.turn_90);
          check_field("false_node", false_node_i, want.flags.false_node);
        end
        result_index++;
      end
      // Track gain writes; other indexes leave the gains alone
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          lsps_pkg::RegPropGain:     kp_gain = lsps_pkg::gain_t'(cfg_data_i);
          lsps_pkg::RegIntegralGain: ki_gain = lsps_pkg::gain_t'(cfg_data_i);
          lsps_pkg::RegDerivGain:    kd_gain = lsps_pkg::gain_t'(cfg_data_i);
          default: ;
        endcase
      end
      // Predict each accepted sample
      if (in_valid_i && !in_stall_i) begin
        expected_steering_q.push_back(predict_steering(sensor_bits_i));
      end
      results_pending_o <= expected_steering_q.size();
    end
  end

endmodule

// ===== tb/tb_line_sensor_pid_steering.sv =====
`timescale 1ns / 1ps

module tb_line_sensor_pid_steering;

  localparam logic [lsps_pkg::CfgIdxW-1:0] RegSpare = 2'd3;
  localparam logic [lsps_pkg::GainW-1:0]   GainMax  = 16'h7FFF;
  localparam logic [lsps_pkg::GainW-1:0]   GainMin  = 16'h8000;
  localparam int unsigned DrainCycles      = 16;
  localparam int unsigned PhaseItems       = 110;
  localparam int unsigned WindupItems      = 60;

  localparam logic [lsps_pkg::SensorCount-1:0] SpecialSamples [6] =
    '{8'h00, 8'hFF, lsps_pkg::NodeAligned, lsps_pkg::NodeRight, lsps_pkg::NodeLeft,
      lsps_pkg::Junction120};
  localparam logic [lsps_pkg::SensorCount-1:0] DirectedSamples [16] =
    '{8'h00, 8'hFF, 8'h99, 8'hCC, 8'h33, 8'h18, 8'h0F, 8'hF0,
      8'h01, 8'h80, 8'hE0, 8'h07, 8'hE7, 8'h10, 8'h08, 8'h81};

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallBlock
  } stall_mode_e;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 cfg_valid = 1'b0;
  logic [lsps_pkg::CfgIdxW-1:0]         cfg_index = '0;
  logic [lsps_pkg::GainW-1:0]           cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic [lsps_pkg::SensorCount-1:0]     sensor_bits = '0;
  logic                                 out_stall = 1'b0;

  logic                                 cfg_ready;
  logic                                 in_stall;
  logic                                 out_valid;
  logic signed [lsps_pkg::ErrW-1:0]     position_error;
  logic [lsps_pkg::DriveW-1:0]          drive_level;
  logic                                 cross_section;
  logic                                 off_line;
  logic                                 node_seen;
  logic                                 junction_120;
  logic                                 turn_90;
  logic                                 false_node;

  int unsigned              mismatch_count;
  int unsigned              results_pending;
  int unsigned              burst_left = 1;
  stall_mode_e              stall_mode = StallNone;
  int unsigned              stall_left = 0;

  line_sensor_pid_steering dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .sensor_bits_i    (sensor_bits),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .position_error_o (position_error),
    .drive_level_o    (drive_level),
    .cross_section_o  (cross_section),
    .off_line_o       (off_line),
    .node_seen_o      (node_seen),
    .junction_120_o   (junction_120),
    .turn_90_o        (turn_90),
    .false_node_o     (false_node)
  );

  line_sensor_pid_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .sensor_bits_i     (sensor_bits),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .position_error_i  (position_error),
    .drive_level_i     (drive_level),
    .cross_section_i   (cross_section),
    .off_line_i        (off_line),
    .node_seen_i       (node_seen),
    .junction_120_i    (junction_120),
    .turn_90_i         (turn_90),
    .false_node_i      (false_node),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver backpressure: hop at random between stall modes
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= stall_left[3];
    endcase
  end

  // Hold one register write until the port takes it
  task automatic write_reg(input logic [lsps_pkg::CfgIdxW-1:0] idx,
                           input logic [lsps_pkg::GainW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic set_gains(input logic [lsps_pkg::GainW-1:0] kp,
                           input logic [lsps_pkg::GainW-1:0] ki,
                           input logic [lsps_pkg::GainW-1:0] kd, input bit spare);
    write_reg(lsps_pkg::RegPropGain, kp);
    write_reg(lsps_pkg::RegIntegralGain, ki);
    write_reg(lsps_pkg::RegDerivGain, kd);
    // Writes to the unused index must be dropped
    if (spare) begin
      write_reg(RegSpare, lsps_pkg::GainW'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // Offer one sample, then maybe close the burst with a gap
  task automatic send_sample(input logic [lsps_pkg::SensorCount-1:0] s);
    int unsigned gap_len;
    in_valid    <= 1'b1;
    sensor_bits <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    burst_left--;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        in_valid    <= 1'b0;
        sensor_bits <= lsps_pkg::SensorCount'($urandom);
        repeat (gap_len) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Stop sending and wait until every predicted result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  function automatic logic [lsps_pkg::GainW-1:0] random_gain();
    case ($urandom_range(0, 7))
      0:       return GainMax;
      1:       return GainMin;
      2:       return '0;
      3:       return lsps_pkg::GainW'($urandom_range(0, 255) - 128);
      default: return lsps_pkg::GainW'($urandom);
    endcase
  endfunction

  function automatic logic [lsps_pkg::SensorCount-1:0] random_sample();
    logic [lsps_pkg::SensorCount-1:0] s;
    s = lsps_pkg::SensorCount'($urandom);
    case ($urandom_range(0, 9))
      0, 1:    s = SpecialSamples[$urandom_range(0, 5)];
      2:       s = s & lsps_pkg::LowerMask;
      3:       s = s & lsps_pkg::UpperMask;
      4:       s = s & ~lsps_pkg::CenterMask;
      default: ;
    endcase
    return s;
  endfunction

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gains: drive must stay zero
    send_sample(8'hE0);
    send_sample(8'h07);
    send_sample(8'h5A);

    // Moderate gains over every flag pattern and both error extremes
    wait_drained();
    set_gains(16'd100, -16'sd7, 16'd3000, 1'b1);
    foreach (DirectedSamples[i]) begin
      send_sample(DirectedSamples[i]);
    end

    // Extreme gains with a full swing of the error
    wait_drained();
    set_gains(GainMax, GainMin, GainMin, 1'b0);
    send_sample(8'hE0);
    send_sample(8'h07);
    send_sample(8'hE0);
    send_sample(8'h00);

    // Random phases, each under its own gain setting
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        1:       set_gains(GainMax, GainMax, GainMax, 1'b0);
        2:       set_gains(GainMin, GainMin, GainMin, 1'b1);
        default: set_gains(random_gain(), random_gain(), random_gain(),
                           $urandom_range(0, 3) == 0);
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 3 && n == PhaseItems / 2) begin
          wait_drained();
        end
        send_sample(random_sample());
      end
    end

    // Push the integral steadily in one direction under extreme gains
    wait_drained();
    set_gains(GainMax, GainMin, GainMax, 1'b0);
    for (int n = 0; n < WindupItems; n++) begin
      send_sample({3'b111, 2'($urandom), 3'b000});
    end
    wait_drained();
    set_gains(GainMin, GainMax, GainMin, 1'b1);
    for (int n = 0; n < 40; n++) begin
      send_sample(random_sample());
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #(6_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== line_sensor_pid_steering.f =====
hdl/lsps_pkg.sv
hdl/lsps_front.sv
hdl/lsps_back.sv
hdl/line_sensor_pid_steering.sv
tb/line_sensor_pid_checker.sv
tb/tb_line_sensor_pid_steering.sv
